[sv/uart_receiver_with_ring_buffer_macros.svh]
// ----------------------------------------------------------------------------
// UART receiver assertion macros
// Shared concurrent assertion forms used by the receiver top level.
// ----------------------------------------------------------------------------
`ifndef UART_RECEIVER_WITH_RING_BUFFER_MACROS_SVH
`define UART_RECEIVER_WITH_RING_BUFFER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define URRB_ASSERT_SAME(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("urrb assertion failed");

// Next-cycle implication, disabled during reset.
`define URRB_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("urrb assertion failed");

`endif

[sv/urrb_pkg.sv]
// ----------------------------------------------------------------------------
// urrb_pkg
// Types and constants for the UART receiver with ring buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package urrb_pkg;

  localparam int TICK_W  = 13;
  localparam int BYTE_W  = 8;
  localparam int FILL_W  = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [TICK_W-1:0] CENTER_RESET = 13'd8;
  localparam logic [TICK_W-1:0] BIT_RESET    = 13'd16;
  localparam logic [TICK_W-1:0] STOP_RESET   = 13'd16;
  localparam logic [TICK_W-1:0] TICK_ONE     = 13'd1;

  localparam logic [2:0] LAST_BIT = 3'd7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CENTER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STOP   = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_CENTER = 4'b0010,
    PH_DATA   = 4'b0100,
    PH_STOP   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] head_byte;
    logic              head_valid;
    logic [FILL_W-1:0] fill_count;
    logic              overflow_flag;
  } result_t;

endpackage

`default_nettype wire

[sv/uart_receiver_with_ring_buffer.sv]
// ----------------------------------------------------------------------------
// uart_receiver_with_ring_buffer
// 8N1 UART receiver, one oversampling tick per input transaction, feeding a
// ring buffer of received bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): one transaction per sample tick with
//   the line level and the host's pop, flush and overflow-clear requests.
//   Output channel (out_valid/out_stall): one result per input transaction,
//   showing head byte, head valid, fill count and overflow flag as they were
//   before that tick's updates.
//   Config channel (cfg_valid/cfg_ready, always ready): writes center, bit
//   period and stop wait tick counts; write only while the block is idle.
// Throughput: one input per cycle while out_stall is low; an accepted input's
//   result is registered into the output register, or the skid entry if the
//   output stalls. The head byte comes from a registered memory read at the
//   next head pointer, with a bypass for a byte written in the same cycle.
// Back-pressure: a two-entry output (register plus skid) lets input flow one
//   more transaction after the receiver stalls; then in_stall rises until the
//   skid entry drains.
// Reset: receiver idle, ring empty, overflow clear, config at 8/16/16. The
//   ring memory itself is not cleared; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "uart_receiver_with_ring_buffer_macros.svh"

module uart_receiver_with_ring_buffer
  import urrb_pkg::*;
#(
  parameter int BUFFER_DEPTH = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // input channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 rx_level,
  input  wire logic                 pop_request,
  input  wire logic                 flush_request,
  input  wire logic                 clear_overflow,
  // output channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [BYTE_W-1:0]         head_byte,
  output logic                      head_valid,
  output logic [FILL_W-1:0]         fill_count,
  output logic                      overflow_flag,
  // configuration
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [TICK_W-1:0]    cfg_data
);

  localparam int PTR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CNT_W = PTR_W + 1;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(BUFFER_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(BUFFER_DEPTH);

  // configuration
  logic [TICK_W-1:0] center_ticks;
  logic [TICK_W-1:0] bit_ticks;
  logic [TICK_W-1:0] stop_ticks;

  // receiver and ring state
  phase_t            rx_phase, rx_phase_next;
  logic [TICK_W-1:0] tick_count, tick_count_next;
  logic [2:0]        bit_index, bit_index_next;
  logic [BYTE_W-1:0] shift_byte, shift_byte_next;
  logic [PTR_W-1:0]  head_ptr, head_ptr_next;
  logic [PTR_W-1:0]  tail_ptr, tail_ptr_next;
  logic              overflow_sticky, overflow_sticky_next;

  logic [BYTE_W-1:0] ring_store [BUFFER_DEPTH];
  logic [BYTE_W-1:0] head_rd;
  logic              wr_en;
  logic [PTR_W-1:0]  wr_addr;
  logic [BYTE_W-1:0] wr_data;

  // output register and skid
  result_t           out_q, skid_q, result;
  logic              skid_valid;
  logic              in_accept, out_take;

  logic              ring_empty;
  logic [CNT_W-1:0]  fill;
  logic [CNT_W+FILL_W-1:0] fill_ext;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign in_accept = in_valid && !skid_valid;
  assign out_take  = out_valid && !out_stall;

  assign head_byte     = out_q.head_byte;
  assign head_valid    = out_q.head_valid;
  assign fill_count    = out_q.fill_count;
  assign overflow_flag = out_q.overflow_flag;

  // ---- result from state before this tick ----
  always_comb begin
    ring_empty = (head_ptr == tail_ptr);
    if (tail_ptr >= head_ptr) begin
      fill = {1'b0, tail_ptr} - {1'b0, head_ptr};
    end else begin
      fill = {1'b0, tail_ptr} + DEPTH_CNT - {1'b0, head_ptr};
    end
    fill_ext = (CNT_W + FILL_W)'(fill);
    result.head_byte     = ring_empty ? '0 : head_rd;
    result.head_valid    = !ring_empty;
    result.fill_count    = fill_ext[FILL_W-1:0];
    result.overflow_flag = overflow_sticky;
  end

  // ---- next state for one tick ----
  always_comb begin
    logic [PTR_W-1:0]  h1;
    logic [PTR_W-1:0]  t1;
    logic [PTR_W-1:0]  nt;
    logic [TICK_W-1:0] period;
    logic [TICK_W-1:0] tick_dec;
    logic [BYTE_W-1:0] sampled;
    logic              due;
    logic              push;

    rx_phase_next        = rx_phase;
    tick_count_next      = tick_count;
    bit_index_next       = bit_index;
    shift_byte_next      = shift_byte;
    head_ptr_next        = head_ptr;
    tail_ptr_next        = tail_ptr;
    overflow_sticky_next = overflow_sticky;
    wr_en                = 1'b0;
    wr_addr              = tail_ptr;
    wr_data              = shift_byte;

    h1 = head_ptr;
    t1 = tail_ptr;
    if (flush_request) begin
      h1 = '0;
      t1 = '0;
    end else if (pop_request && !ring_empty) begin
      h1 = (head_ptr == LAST_SLOT) ? '0 : head_ptr + 1'b1;
    end
    nt = (t1 == LAST_SLOT) ? '0 : t1 + 1'b1;

    period   = (bit_ticks == '0) ? TICK_ONE : bit_ticks;
    due      = (tick_count <= TICK_ONE);
    tick_dec = due ? '0 : tick_count - TICK_ONE;
    sampled  = shift_byte;
    sampled[bit_index] = rx_level;
    push     = 1'b0;

    case (rx_phase)
      PH_IDLE: begin
        if (!rx_level) begin
          shift_byte_next = '0;
          bit_index_next  = '0;
          if (center_ticks == '0) begin
            rx_phase_next   = PH_DATA;
            tick_count_next = period;
          end else begin
            rx_phase_next   = PH_CENTER;
            tick_count_next = center_ticks;
          end
        end
      end
      PH_CENTER: begin
        tick_count_next = tick_dec;
        if (due) begin
          rx_phase_next   = PH_DATA;
          tick_count_next = period;
          bit_index_next  = '0;
        end
      end
      PH_DATA: begin
        tick_count_next = tick_dec;
        if (due) begin
          shift_byte_next = sampled;
          if (bit_index == LAST_BIT) begin
            bit_index_next = '0;
            if (stop_ticks == '0) begin
              push            = 1'b1;
              rx_phase_next   = PH_IDLE;
              tick_count_next = '0;
            end else begin
              rx_phase_next   = PH_STOP;
              tick_count_next = stop_ticks;
            end
          end else begin
            bit_index_next  = bit_index + 1'b1;
            tick_count_next = period;
          end
        end
      end
      PH_STOP: begin
        tick_count_next = tick_dec;
        if (due) begin
          push            = 1'b1;
          rx_phase_next   = PH_IDLE;
          tick_count_next = '0;
        end
      end
      default: begin
        rx_phase_next   = PH_IDLE;
        tick_count_next = '0;
      end
    endcase

    overflow_sticky_next = clear_overflow ? 1'b0 : overflow_sticky;
    tail_ptr_next = t1;
    wr_addr       = t1;
    wr_data       = shift_byte_next;
    if (push) begin
      if (nt != h1) begin
        wr_en         = 1'b1;
        tail_ptr_next = nt;
      end else begin
        overflow_sticky_next = 1'b1;
      end
    end
    head_ptr_next = h1;

    // hold everything when no transaction is accepted
    if (!in_accept) begin
      rx_phase_next        = rx_phase;
      tick_count_next      = tick_count;
      bit_index_next       = bit_index;
      shift_byte_next      = shift_byte;
      head_ptr_next        = head_ptr;
      tail_ptr_next        = tail_ptr;
      overflow_sticky_next = overflow_sticky;
      wr_en                = 1'b0;
    end
  end

  // ---- state registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_phase        <= PH_IDLE;
      tick_count      <= '0;
      bit_index       <= '0;
      shift_byte      <= '0;
      head_ptr        <= '0;
      tail_ptr        <= '0;
      overflow_sticky <= 1'b0;
    end else begin
      rx_phase        <= rx_phase_next;
      tick_count      <= tick_count_next;
      bit_index       <= bit_index_next;
      shift_byte      <= shift_byte_next;
      head_ptr        <= head_ptr_next;
      tail_ptr        <= tail_ptr_next;
      overflow_sticky <= overflow_sticky_next;
    end
  end

  // ---- configuration registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      center_ticks <= CENTER_RESET;
      bit_ticks    <= BIT_RESET;
      stop_ticks   <= STOP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CENTER: center_ticks <= cfg_data;
        REG_BIT:    bit_ticks    <= cfg_data;
        REG_STOP:   stop_ticks   <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- ring memory: read at the next head, bypass a same-cycle write ----
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_store[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == head_ptr_next)) begin
      head_rd <= wr_data;
    end else begin
      head_rd <= ring_store[head_ptr_next];
    end
  end

  // ---- output register and skid ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_take) begin
          skid_valid <= 1'b0;
        end
      end else if (in_accept) begin
        if (out_valid && !out_take) begin
          skid_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (in_accept) begin
      if (out_valid && !out_take) begin
        skid_q <= result;
      end else begin
        out_q <= result;
      end
    end
  end

  // ---- assertions ----
  `URRB_ASSERT_SAME(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  `URRB_ASSERT_SAME(a_idle_bit_zero, clk, rst, rx_phase == PH_IDLE, bit_index == '0)
  `URRB_ASSERT_NEXT(a_start_leaves_idle, clk, rst,
                    in_accept && rx_phase == PH_IDLE && !rx_level, rx_phase != PH_IDLE)
  `URRB_ASSERT_NEXT(a_result_follows_accept, clk, rst, in_accept, out_valid)

endmodule

`default_nettype wire
